@@ hw/rtl/pdd_pkg.sv @@
// Shared constants and types for the packet digest duplicate filter.
package pdd_pkg;

	localparam int DIGEST_WIDTH       = 256;
	localparam int WORD_WIDTH         = 64;
	localparam int TTL_WIDTH          = 16;
	localparam int NOW_WIDTH          = 32;
	localparam int ENTRIES_DEFAULT    = 48;
	localparam int TIME_WIDTH_DEFAULT = 32;
	localparam int GROUP_SIZE         = 8;

	localparam logic [TTL_WIDTH-1:0] TTL_RESET = 16'd750;

	typedef logic [DIGEST_WIDTH-1:0] digest_t;

endpackage

@@ hw/rtl/packet_digest_dedupe_filter.sv @@
// Top level of the packet digest duplicate filter with time-to-live.
//
// Each input transfer carries a 256-bit packet digest and the current time in
// milliseconds; each produces one output transfer whose is_duplicate flag is set
// when a valid stored entry holds the same digest and its modular age
// (now_ms - arrival time, modulo 2^TIME_WIDTH) is below ttl_ms. A new digest is
// pushed into the head of a chain of ENTRIES cells and every entry moves one
// cell on, so the oldest entry drops off the end once the table is full; a
// duplicate leaves the table unchanged. The query register loads at the input
// transfer, then the per-cell compare register, the group OR register and the
// decision follow in that order; the decision loads the output register and
// performs the insertion. The input side reopens in the same cycle that the
// result is presented. The block then takes the next item at once, while the
// result may still wait in the output register; if a second result completes
// while the first has not been taken, it waits in the decision step. ttl_ms
// resets to 750 and is written through cfg_wr_en and cfg_wr_data; the user
// must write it only while idle, which the block does not enforce.
module packet_digest_dedupe_filter
	import pdd_pkg::*;
#(
	parameter int ENTRIES    = ENTRIES_DEFAULT,
	parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [TTL_WIDTH-1:0]  cfg_wr_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [WORD_WIDTH-1:0] digest_word_0,
	input  logic [WORD_WIDTH-1:0] digest_word_1,
	input  logic [WORD_WIDTH-1:0] digest_word_2,
	input  logic [WORD_WIDTH-1:0] digest_word_3,
	input  logic [NOW_WIDTH-1:0]  now_ms,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  is_duplicate
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_GRP,
		ST_FIN
	} state_t;

	state_t                state_q;
	logic [TTL_WIDTH-1:0]  ttl_q;
	digest_t               query_digest_q;
	logic [TIME_WIDTH-1:0] query_time_q;
	logic                  out_valid_q;
	logic                  is_duplicate_q;

	logic                  in_xfer;
	logic                  out_free;
	logic                  fin_go;
	logic                  any_hit;
	logic                  shift_en;

	logic [ENTRIES-1:0]    valid_vec;
	logic [ENTRIES-1:0]    hit_vec;
	digest_t               digest_arr [ENTRIES];
	logic [TIME_WIDTH-1:0] time_arr   [ENTRIES];

	// Handshake and decision conditions.
	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign fin_go   = (state_q == ST_FIN) && out_free;
	assign shift_en = fin_go && !any_hit;

	// Time-to-live register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q <= TTL_RESET;
		end else if (cfg_wr_en) begin
			ttl_q <= cfg_wr_data;
		end
	end

	// Query held for the whole compare; the time is reduced to the table width.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			query_digest_q <= {digest_word_0, digest_word_1, digest_word_2, digest_word_3};
			query_time_q   <= TIME_WIDTH'(now_ms);
		end
	end

	// Sequencer with the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			out_valid_q    <= 1'b0;
			is_duplicate_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_GRP;
				end
				ST_GRP: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q    <= 1'b1;
						is_duplicate_q <= any_hit;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Chain of cells; the head takes the query on an insertion.
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		if (i == 0) begin : g_head
			pdd_cell #(
				.TIME_WIDTH (TIME_WIDTH)
			) u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.shift_en     (shift_en),
				.prev_valid   (1'b1),
				.prev_digest  (query_digest_q),
				.prev_time    (query_time_q),
				.query_digest (query_digest_q),
				.query_time   (query_time_q),
				.ttl          (ttl_q),
				.entry_valid  (valid_vec[i]),
				.entry_digest (digest_arr[i]),
				.entry_time   (time_arr[i]),
				.hit          (hit_vec[i])
			);
		end else begin : g_body
			pdd_cell #(
				.TIME_WIDTH (TIME_WIDTH)
			) u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.shift_en     (shift_en),
				.prev_valid   (valid_vec[i-1]),
				.prev_digest  (digest_arr[i-1]),
				.prev_time    (time_arr[i-1]),
				.query_digest (query_digest_q),
				.query_time   (query_time_q),
				.ttl          (ttl_q),
				.entry_valid  (valid_vec[i]),
				.entry_digest (digest_arr[i]),
				.entry_time   (time_arr[i]),
				.hit          (hit_vec[i])
			);
		end
	end

	// Fold the match flags of all cells.
	pdd_hit_reduce #(
		.ENTRIES (ENTRIES)
	) u_reduce (
		.clk     (clk),
		.arst_n  (arst_n),
		.hits    (hit_vec),
		.any_hit (any_hit)
	);

	assign out_valid    = out_valid_q;
	assign is_duplicate = is_duplicate_q;

`ifndef SYNTHESIS
	// An accepted item keeps the input side closed for the compare cycles.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("input accepted during a compare");

	// An insertion always leaves a valid entry at the head of the chain.
	assert property (@(posedge clk) disable iff (!arst_n)
		shift_en |=> valid_vec[0])
		else $error("inserted entry not valid at the head");

	// A duplicate leaves the table untouched.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && any_hit) |=> $stable(valid_vec))
		else $error("table changed on a duplicate");

	// A result is loaded only from the decision step.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result appeared outside the decision step");
`endif

endmodule

@@ hw/rtl/pdd_cell.sv @@
// One table cell: holds a stored digest, its arrival time and valid bit, and tests the query.
module pdd_cell
	import pdd_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  shift_en,
	input  logic                  prev_valid,
	input  digest_t               prev_digest,
	input  logic [TIME_WIDTH-1:0] prev_time,
	input  digest_t               query_digest,
	input  logic [TIME_WIDTH-1:0] query_time,
	input  logic [TTL_WIDTH-1:0]  ttl,
	output logic                  entry_valid,
	output digest_t               entry_digest,
	output logic [TIME_WIDTH-1:0] entry_time,
	output logic                  hit
);

	logic                  valid_q;
	digest_t               digest_q;
	logic [TIME_WIDTH-1:0] time_q;
	logic [TIME_WIDTH-1:0] age;
	logic                  hit_q;

	// The valid bit moves along the chain with its entry on every insertion.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift_en) begin
			valid_q <= prev_valid;
		end
	end

	// Stored payload takes over the neighbour's entry on an insertion.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			digest_q <= prev_digest;
			time_q   <= prev_time;
		end
	end

	// Modular age, so the time counter may wrap.
	assign age = query_time - time_q;

	// Registered match: valid, same digest and younger than the time-to-live.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else begin
			hit_q <= valid_q && (digest_q == query_digest) && (age < TIME_WIDTH'(ttl));
		end
	end

	assign entry_valid  = valid_q;
	assign entry_digest = digest_q;
	assign entry_time   = time_q;
	assign hit          = hit_q;

endmodule

@@ hw/rtl/pdd_hit_reduce.sv @@
// Registered OR tree that folds the per-cell match flags into one hit flag.
module pdd_hit_reduce
	import pdd_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [ENTRIES-1:0] hits,
	output logic               any_hit
);

	localparam int NGROUPS = (ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int PADDED  = NGROUPS * GROUP_SIZE;

	logic [PADDED-1:0]  hits_pad;
	logic [NGROUPS-1:0] grp_q;

	// Unused lanes of the last group read as no match.
	assign hits_pad = PADDED'(hits);

	// First level: one register per group of cells.
	for (genvar g = 0; g < NGROUPS; g++) begin : g_grp
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				grp_q[g] <= 1'b0;
			end else begin
				grp_q[g] <= |hits_pad[g*GROUP_SIZE +: GROUP_SIZE];
			end
		end
	end

	// Second level is a narrow OR, taken by the decision logic.
	assign any_hit = |grp_q;

endmodule

@@ sim/tb_packet_digest_dedupe_filter.sv @@
// Testbench for the packet digest duplicate filter: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_packet_digest_dedupe_filter;
	import pdd_pkg::*;

	localparam int FILTER_DEPTH  = ENTRIES_DEFAULT;
	localparam int ITEMS_PER_SET = 220;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int PRINT_LIMIT   = 40;
	localparam int HISTORY_DEPTH = 64;

	// One row of the directed stimulus; dup_given holds a hand-written expectation.
	typedef struct {
		digest_t         digest;
		logic [31:0]     stamp;
		bit              has_given;
		bit              dup_given;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  cfg_wr_en     = 1'b0;
	logic [TTL_WIDTH-1:0]  cfg_wr_data   = '0;
	logic                  in_valid      = 1'b0;
	logic                  in_ready;
	logic [WORD_WIDTH-1:0] digest_word_0 = '0;
	logic [WORD_WIDTH-1:0] digest_word_1 = '0;
	logic [WORD_WIDTH-1:0] digest_word_2 = '0;
	logic [WORD_WIDTH-1:0] digest_word_3 = '0;
	logic [NOW_WIDTH-1:0]  now_ms        = '0;
	logic                  out_valid;
	logic                  out_ready     = 1'b0;
	logic                  is_duplicate;

	// Shadow copy of the filter table and its time-to-live.
	digest_t               seen_digest [FILTER_DEPTH];
	logic [NOW_WIDTH-1:0]  seen_stamp  [FILTER_DEPTH];
	bit                    seen_valid  [FILTER_DEPTH];
	int                    seen_head;
	logic [TTL_WIDTH-1:0]  ttl_shadow;

	bit                    dup_expect_q [$];
	digest_t               recent_digests [$];
	stim_row_t             directed_rows [$];
	logic [NOW_WIDTH-1:0]  clock_ms;
	int                    burst_left;
	bit                    drain_request;
	int                    error_count  = 0;
	int                    cycle_count  = 0;
	int                    results_seen = 0;
	int                    stall_mode   = 0;
	int                    stall_left   = 0;

	packet_digest_dedupe_filter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.digest_word_0(digest_word_0),
		.digest_word_1(digest_word_1),
		.digest_word_2(digest_word_2),
		.digest_word_3(digest_word_3),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.is_duplicate (is_duplicate)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= PRINT_LIMIT)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	// Looks the digest up in the shadow table; a miss stores it at the ring head.
	function automatic bit predict_duplicate(input digest_t digest, input logic [31:0] stamp);
		logic [NOW_WIDTH-1:0] age;
		bit                   hit;
		int                   i;
		hit = 1'b0;
		for (i = 0; i < FILTER_DEPTH; i++) begin
			age = stamp - seen_stamp[i];
			if (seen_valid[i] && age < ttl_shadow && seen_digest[i] == digest)
				hit = 1'b1;
		end
		if (!hit) begin
			seen_digest[seen_head] = digest;
			seen_stamp[seen_head]  = stamp;
			seen_valid[seen_head]  = 1'b1;
			seen_head = (seen_head == FILTER_DEPTH - 1) ? 0 : seen_head + 1;
		end
		return hit;
	endfunction

	// Presents one digest and holds it until the transfer, then records the expectation.
	task automatic drive_item(input digest_t digest, input logic [31:0] stamp,
			input bit has_given, input bit dup_given);
		bit predicted;
		in_valid      <= 1'b1;
		digest_word_0 <= digest[255:192];
		digest_word_1 <= digest[191:128];
		digest_word_2 <= digest[127:64];
		digest_word_3 <= digest[63:0];
		now_ms        <= stamp;
		do @(posedge clk); while (!in_ready);
		predicted = predict_duplicate(digest, stamp);
		dup_expect_q.push_back(has_given ? dup_given : predicted);
		recent_digests.push_back(digest);
		if (recent_digests.size() > HISTORY_DEPTH)
			void'(recent_digests.pop_front());
	endtask

	// Bursts of back-to-back transfers separated by random gaps; a gap may wait for a drain.
	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			if (drain_request) begin
				while (dup_expect_q.size() != 0) @(posedge clk);
				repeat (SETTLE_CYCLES) @(posedge clk);
				drain_request = 1'b0;
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
			                                          : $urandom_range(0, 10);
		end
	endtask

	// Stops the sender and waits until every outstanding result has been taken.
	task automatic quiesce();
		burst_left    = 0;
		drain_request = 1'b1;
		pace_sender();
	endtask

	task automatic write_ttl(input logic [TTL_WIDTH-1:0] value);
		quiesce();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		ttl_shadow = value;
	endtask

	// Mostly replays recent digests with a drifting clock so that both hits and
	// expiries occur; the rest are near misses, fresh digests and clock jumps.
	task automatic send_random_item();
		digest_t digest;
		int      pick;
		int      cap;
		int      flip;
		cap  = (ttl_shadow >> 4) + 1;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			clock_ms = $urandom();
		else if (pick < 6)
			clock_ms = clock_ms - $urandom_range(1, 2 * cap);
		else if (pick < 8)
			clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 4 * cap);
		else
			clock_ms = clock_ms + $urandom_range(0, cap);

		pick = $urandom_range(0, 99);
		if (pick < 55 && recent_digests.size() != 0) begin
			digest = recent_digests[$urandom_range(0, recent_digests.size() - 1)];
		end else if (pick < 63 && recent_digests.size() != 0) begin
			digest = recent_digests[$urandom_range(0, recent_digests.size() - 1)];
			flip = $urandom_range(0, DIGEST_WIDTH - 1);
			digest[flip] = ~digest[flip];
		end else begin
			digest = {$urandom(), $urandom(), $urandom(), $urandom(),
			          $urandom(), $urandom(), $urandom(), $urandom()};
		end
		drive_item(digest, clock_ms, 1'b0, 1'b0);
	endtask

	task automatic add_row(input digest_t digest, input logic [31:0] stamp,
			input bit has_given, input bit dup_given);
		stim_row_t row;
		row.digest    = digest;
		row.stamp     = stamp;
		row.has_given = has_given;
		row.dup_given = dup_given;
		directed_rows.push_back(row);
	endtask

	// Result side: stalls on its own pattern and checks every transfer in order.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(10, 150);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: begin
				out_ready <= 1'b1;
			end
			1: begin
				out_ready <= 1'($urandom_range(0, 1));
			end
			default: begin
				out_ready <= ($urandom_range(0, 4) == 0);
			end
		endcase
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (dup_expect_q.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with none expected",
					results_seen));
			end else if (is_duplicate !== dup_expect_q[0]) begin
				report_mismatch($sformatf("result %0d: is_duplicate %b, expected %b",
					results_seen, is_duplicate, dup_expect_q[0]));
				void'(dup_expect_q.pop_front());
			end else begin
				void'(dup_expect_q.pop_front());
			end
		end
	end

	initial begin
		digest_t              ones;
		digest_t              pattern;
		digest_t              rand_digest;
		logic [TTL_WIDTH-1:0] ttl_plan [6];
		int                   set_idx;
		int                   k;
		int                   i;

		burst_left    = 0;
		drain_request = 1'b0;
		seen_head     = 0;
		ttl_shadow    = TTL_RESET;
		clock_ms      = 32'd5000;
		for (i = 0; i < FILTER_DEPTH; i++) begin
			seen_valid[i]  = 1'b0;
			seen_digest[i] = '0;
			seen_stamp[i]  = '0;
		end

		// Reset is held low and released at a clock edge.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		ones        = '1;
		pattern     = {4{64'hAAAA_AAAA_5555_5555}};
		rand_digest = {$urandom(), $urandom(), $urandom(), $urandom(),
		               $urandom(), $urandom(), $urandom(), $urandom()};

		// Empty table, age just inside and exactly at the time-to-live.
		add_row(ones, 32'd0,   1'b1, 1'b0);
		add_row(ones, 32'd749, 1'b1, 1'b1);
		add_row(ones, 32'd750, 1'b1, 1'b0);
		// Two stored copies, the older one expired.
		add_row(ones, 32'd760, 1'b0, 1'b0);
		// Time counter wrapping, then a stored time lying in the future.
		add_row('0, 32'hFFFF_FFF0, 1'b1, 1'b0);
		add_row('0, 32'h0000_0010, 1'b0, 1'b0);
		add_row('0, 32'hFFFF_FFE0, 1'b0, 1'b0);
		// Several live entries hold the same digest.
		add_row('0, 32'hFFFF_FFFF, 1'b0, 1'b0);
		// Digests differing from a stored one in a single bit.
		add_row(ones ^ digest_t'(1), 32'd800, 1'b0, 1'b0);
		add_row(ones ^ (digest_t'(1) << 255), 32'd800, 1'b0, 1'b0);
		add_row(pattern,  32'd1000, 1'b0, 1'b0);
		add_row(~pattern, 32'd1000, 1'b0, 1'b0);
		add_row(pattern,  32'd1749, 1'b0, 1'b0);
		add_row(~pattern, 32'd1750, 1'b0, 1'b0);
		add_row(rand_digest, 32'h8000_0000, 1'b0, 1'b0);
		add_row(rand_digest, 32'h8000_0000, 1'b1, 1'b1);

		foreach (directed_rows[r]) begin
			drive_item(directed_rows[r].digest, directed_rows[r].stamp,
				directed_rows[r].has_given, directed_rows[r].dup_given);
			pace_sender();
		end

		// Random traffic under a sequence of time-to-live settings, extremes included.
		ttl_plan[0] = TTL_RESET;
		ttl_plan[1] = 16'd1;
		ttl_plan[2] = 16'hFFFF;
		ttl_plan[3] = 16'd0;
		ttl_plan[4] = TTL_WIDTH'($urandom_range(2, 65534));
		ttl_plan[5] = 16'd40;
		for (set_idx = 0; set_idx < 6; set_idx++) begin
			if (set_idx != 0)
				write_ttl(ttl_plan[set_idx]);
			for (k = 0; k < ITEMS_PER_SET; k++) begin
				if (k == ITEMS_PER_SET / 2)
					drain_request = 1'b1;
				send_random_item();
				pace_sender();
			end
		end

		quiesce();
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
